>>> sv/csdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdf_pkg
// Shared types, register indexes and reset values for the coupler force block.
// ----------------------------------------------------------------------------
package csdf_pkg;

  localparam int POSITION_WIDTH_DEF = 40;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int SPEED_W  = 24;
  localparam int COEF_W   = 26;
  localparam int PLAY_W   = 16;
  localparam int REST_W   = 39;
  localparam int FORCE_W  = 48;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 39;

  localparam logic [COEF_W-1:0] STIFF_RST = COEF_W'(12000000);
  localparam logic [COEF_W-1:0] DAMP_RST  = COEF_W'(1200000);
  localparam logic [PLAY_W-1:0] PLAY_RST  = PLAY_W'(1966);

  typedef enum logic [CFG_AW-1:0] {
    CFG_OWN_STIFF  = 3'd0,
    CFG_OWN_DAMP   = 3'd1,
    CFG_PEER_STIFF = 3'd2,
    CFG_PEER_DAMP  = 3'd3,
    CFG_FREE_PLAY  = 3'd4,
    CFG_REST_DIST  = 3'd5,
    CFG_FRONT_SIDE = 3'd6,
    CFG_COUPLED    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_UNCOUPLED = 2'd0,
    MODE_OPEN      = 2'd1,
    MODE_FREE_PLAY = 2'd2,
    MODE_TRANSMIT  = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] own_speed;
    logic signed [SPEED_W-1:0] peer_speed;
    logic                      own_open;
    logic                      peer_open;
  } side_t;

endpackage
`default_nettype wire

>>> sv/coupler_spring_damper_force.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: axis magnitudes, partial products, squares, sum of squares,
//   then one square root stage per root bit, then P1 to P4 and the output register.
// Throughput: one request per cycle; a stalled output freezes the whole pipeline.
// Reset (rst_n low, synchronous): pipeline empty, configuration registers at their defaults.
// ----------------------------------------------------------------------------
// coupler_spring_damper_force
// Spring-damper coupler force with free play, fully pipelined.
// ----------------------------------------------------------------------------
module coupler_spring_damper_force #(
  parameter int POSITION_WIDTH = csdf_pkg::POSITION_WIDTH_DEF,
  parameter int FRACTION_BITS  = csdf_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [POSITION_WIDTH-1:0]       in_own_pos_x,
  input  wire logic signed [POSITION_WIDTH-1:0]       in_own_pos_y,
  input  wire logic signed [POSITION_WIDTH-1:0]       in_own_pos_z,
  input  wire logic signed [POSITION_WIDTH-1:0]       in_peer_pos_x,
  input  wire logic signed [POSITION_WIDTH-1:0]       in_peer_pos_y,
  input  wire logic signed [POSITION_WIDTH-1:0]       in_peer_pos_z,
  input  wire logic signed [csdf_pkg::SPEED_W-1:0]    in_own_speed,
  input  wire logic signed [csdf_pkg::SPEED_W-1:0]    in_peer_speed,
  input  wire logic                                   in_own_open,
  input  wire logic                                   in_peer_open,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [csdf_pkg::FORCE_W-1:0]         out_force_res,
  output logic [1:0]                                  out_mode,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [csdf_pkg::CFG_AW-1:0]            cfg_addr,
  input  wire logic [csdf_pkg::CFG_DW-1:0]            cfg_wdata
);
  import csdf_pkg::*;

  localparam int PW  = POSITION_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int DW  = (PW == 64) ? PW - 1 : PW;
  localparam int H   = (DW + 1) / 2;
  localparam int HW  = DW - H;
  localparam int RW  = DW + 1;
  localparam int NW  = 2 * RW;
  localparam int RMW = RW + 3;
  localparam int SW  = (RW > REST_W) ? RW : REST_W;
  localparam int NC  = (SW + 31) / 32;
  localparam int KW  = COEF_W + 1;
  localparam int T1W = KW + NC * 32;
  localparam int FW  = T1W + 2;
  localparam int SDW = SPEED_W + 1;

  localparam logic [PW:0] MAXD = ({{PW{1'b0}}, 1'b1} << DW) - 1'b1;
  localparam logic signed [FW-1:0] FMAX = FW'({(FORCE_W-1){1'b1}});
  localparam logic signed [FW-1:0] FMIN = ~FMAX;
  localparam logic signed [FW-1:0] HALF = {{(FW-1){1'b0}}, 1'b1} << FB;

  // configuration
  logic [COEF_W-1:0] own_stiff_r, own_damp_r, peer_stiff_r, peer_damp_r;
  logic [PLAY_W-1:0] free_play_r;
  logic [REST_W-1:0] rest_dist_r;
  logic              front_side_r, coupled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_stiff_r  <= STIFF_RST;
      own_damp_r   <= DAMP_RST;
      peer_stiff_r <= STIFF_RST;
      peer_damp_r  <= DAMP_RST;
      free_play_r  <= PLAY_RST;
      rest_dist_r  <= '0;
      front_side_r <= 1'b0;
      coupled_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_OWN_STIFF:  own_stiff_r  <= cfg_wdata[COEF_W-1:0];
        CFG_OWN_DAMP:   own_damp_r   <= cfg_wdata[COEF_W-1:0];
        CFG_PEER_STIFF: peer_stiff_r <= cfg_wdata[COEF_W-1:0];
        CFG_PEER_DAMP:  peer_damp_r  <= cfg_wdata[COEF_W-1:0];
        CFG_FREE_PLAY:  free_play_r  <= cfg_wdata[PLAY_W-1:0];
        CFG_REST_DIST:  rest_dist_r  <= cfg_wdata[REST_W-1:0];
        CFG_FRONT_SIDE: front_side_r <= cfg_wdata[0];
        CFG_COUPLED:    coupled_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage 1: axis difference magnitudes
  logic [PW-1:0]        own_p[3], peer_p[3];
  logic signed [PW:0]   dif[3];
  logic [PW:0]          mag[3];
  logic [DW-1:0]        s1_d_nxt[3], s1_d_r[3];
  side_t                in_side, s1_side_r, s2_side_r, s3_side_r, s4_side_r;
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  assign own_p[0]  = in_own_pos_x;
  assign own_p[1]  = in_own_pos_y;
  assign own_p[2]  = in_own_pos_z;
  assign peer_p[0] = in_peer_pos_x;
  assign peer_p[1] = in_peer_pos_y;
  assign peer_p[2] = in_peer_pos_z;
  assign in_side   = '{own_speed: in_own_speed, peer_speed: in_peer_speed,
                       own_open: in_own_open, peer_open: in_peer_open};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dif[a] = $signed({peer_p[a][PW-1], peer_p[a]}) - $signed({own_p[a][PW-1], own_p[a]});
      mag[a] = dif[a][PW] ? $unsigned(-dif[a]) : $unsigned(dif[a]);
      s1_d_nxt[a] = (mag[a] > MAXD) ? MAXD[DW-1:0] : mag[a][DW-1:0];
    end
  end

  // stage 2: partial products, stage 3: squares, stage 4: sum of squares
  logic [2*HW-1:0]   s2_hh_nxt[3], s2_hh_r[3];
  logic [HW+H-1:0]   s2_hl_nxt[3], s2_hl_r[3];
  logic [2*H-1:0]    s2_ll_nxt[3], s2_ll_r[3];
  logic [2*DW-1:0]   s3_sq_nxt[3], s3_sq_r[3];
  logic [NW-1:0]     s4_sum_nxt, s4_sum_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s2_hh_nxt[a] = (2*HW)'(s1_d_r[a][DW-1:H]) * (2*HW)'(s1_d_r[a][DW-1:H]);
      s2_hl_nxt[a] = (HW+H)'(s1_d_r[a][DW-1:H]) * (HW+H)'(s1_d_r[a][H-1:0]);
      s2_ll_nxt[a] = (2*H)'(s1_d_r[a][H-1:0]) * (2*H)'(s1_d_r[a][H-1:0]);
      s3_sq_nxt[a] = ((2*DW)'(s2_hh_r[a]) << (2*H)) + ((2*DW)'(s2_hl_r[a]) << (H+1))
                   + (2*DW)'(s2_ll_r[a]);
    end
    s4_sum_nxt = NW'(s3_sq_r[0]) + NW'(s3_sq_r[1]) + NW'(s3_sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r    <= s1_d_nxt;
      s1_side_r <= in_side;
      s2_hh_r   <= s2_hh_nxt;
      s2_hl_r   <= s2_hl_nxt;
      s2_ll_r   <= s2_ll_nxt;
      s2_side_r <= s1_side_r;
      s3_sq_r   <= s3_sq_nxt;
      s3_side_r <= s2_side_r;
      s4_sum_r  <= s4_sum_nxt;
      s4_side_r <= s3_side_r;
    end
  end

  // square root: one restoring step per stage
  logic [RMW-1:0] q_rem_nxt[RW],  q_rem_r[RW];
  logic [RW-1:0]  q_root_nxt[RW], q_root_r[RW];
  logic [NW-1:0]  q_rad_nxt[RW],  q_rad_r[RW];
  logic           q_v_r[RW];
  side_t          q_side_r[RW];
  logic [RMW-1:0] rem_in[RW], rsh[RW], trial[RW];
  logic [RW-1:0]  root_in[RW];
  logic [NW-1:0]  rad_in[RW];

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        root_in[k] = '0;
        rad_in[k]  = s4_sum_r;
      end else begin
        rem_in[k]  = q_rem_r[k-1];
        root_in[k] = q_root_r[k-1];
        rad_in[k]  = q_rad_r[k-1];
      end
      rsh[k]   = {rem_in[k][RMW-3:0], rad_in[k][NW-1 -: 2]};
      trial[k] = RMW'({root_in[k], 2'b01});
      if (rsh[k] >= trial[k]) begin
        q_rem_nxt[k]  = rsh[k] - trial[k];
        q_root_nxt[k] = {root_in[k][RW-2:0], 1'b1};
      end else begin
        q_rem_nxt[k]  = rsh[k];
        q_root_nxt[k] = {root_in[k][RW-2:0], 1'b0};
      end
      q_rad_nxt[k] = rad_in[k] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RW; k++) q_v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < RW; k++) q_v_r[k] <= (k == 0) ? s4_v_r : q_v_r[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_rem_r  <= q_rem_nxt;
      q_root_r <= q_root_nxt;
      q_rad_r  <= q_rad_nxt;
      for (int k = 0; k < RW; k++) begin
        q_side_r[k] <= (k == 0) ? s4_side_r : q_side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // P1: stretch, dead band, speed difference, mode
  side_t             dside;
  logic [SW-1:0]     dist_x, rest_x, smag;
  logic              stretching, sneg;
  logic signed [SDW-1:0] sd;
  mode_t             p1_mode_nxt, p1_mode_r, p2_mode_r, p3_mode_r;
  logic [SW-1:0]     p1_smag_nxt, p1_smag_r;
  logic [SDW-1:0]    p1_sdmag_nxt, p1_sdmag_r;
  logic              p1_sneg_r, p1_sdneg_r, p2_sneg_r, p2_sdneg_r;
  logic [KW-1:0]     p1_ksum_r, p1_rsum_r;
  logic              p1_v_r, p2_v_r, p3_v_r;

  assign dside  = q_side_r[RW-1];
  assign dist_x = SW'(q_root_r[RW-1]);
  assign rest_x = SW'(rest_dist_r);

  always_comb begin
    stretching = dist_x > rest_x;
    sneg       = dist_x < rest_x;
    smag       = sneg ? rest_x - dist_x : dist_x - rest_x;
    if (!coupled_r) begin
      p1_mode_nxt = MODE_UNCOUPLED;
    end else if (stretching && (dside.own_open || dside.peer_open)) begin
      p1_mode_nxt = MODE_OPEN;
    end else if (smag <= SW'(free_play_r)) begin
      p1_mode_nxt = MODE_FREE_PLAY;
    end else begin
      p1_mode_nxt = MODE_TRANSMIT;
    end
    p1_smag_nxt = smag - SW'(free_play_r);
    sd = front_side_r
       ? $signed({dside.peer_speed[SPEED_W-1], dside.peer_speed})
         - $signed({dside.own_speed[SPEED_W-1], dside.own_speed})
       : $signed({dside.own_speed[SPEED_W-1], dside.own_speed})
         - $signed({dside.peer_speed[SPEED_W-1], dside.peer_speed});
    p1_sdmag_nxt = sd[SDW-1] ? $unsigned(-sd) : $unsigned(sd);
  end

  // P2: products, P3: signed terms
  logic [NC*32-1:0]     smag_pad;
  logic [KW+31:0]       p2_pk_nxt[NC], p2_pk_r[NC];
  logic [KW+SDW-1:0]    p2_t2_nxt, p2_t2_r;
  logic signed [FW-1:0] p3_t1_nxt, p3_t1_r, p3_t2_nxt, p3_t2_r;

  assign smag_pad = (NC*32)'(p1_smag_r);

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      p2_pk_nxt[c] = (KW+32)'(p1_ksum_r) * (KW+32)'(smag_pad[c*32 +: 32]);
    end
    p2_t2_nxt = (KW+SDW)'(p1_rsum_r) * (KW+SDW)'(p1_sdmag_r);
  end

  always_comb begin
    logic [T1W-1:0] acc;
    acc = '0;
    for (int c = 0; c < NC; c++) acc = acc + (T1W'(p2_pk_r[c]) << (32 * c));
    p3_t1_nxt = p2_sneg_r ? -$signed(FW'(acc)) : $signed(FW'(acc));
    p3_t2_nxt = p2_sdneg_r ? -$signed(FW'(p2_t2_r)) : $signed(FW'(p2_t2_r));
  end

  // P4: round, saturate, zero the force outside transmitting mode
  logic signed [FW-1:0]      total, shifted, sat;
  logic signed [FORCE_W-1:0] out_force_nxt, out_force_res_r;
  mode_t                     out_mode_r;

  always_comb begin
    total   = p3_t1_r + p3_t2_r + HALF;
    shifted = total >>> (FB + 1);
    if (shifted > FMAX) begin
      sat = FMAX;
    end else if (shifted < FMIN) begin
      sat = FMIN;
    end else begin
      sat = shifted;
    end
    out_force_nxt = (p3_mode_r == MODE_TRANSMIT) ? sat[FORCE_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_v_r      <= q_v_r[RW-1];
      p2_v_r      <= p1_v_r;
      p3_v_r      <= p2_v_r;
      out_valid_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_mode_r       <= p1_mode_nxt;
      p1_sneg_r       <= sneg;
      p1_smag_r       <= p1_smag_nxt;
      p1_sdneg_r      <= sd[SDW-1];
      p1_sdmag_r      <= p1_sdmag_nxt;
      p1_ksum_r       <= KW'(own_stiff_r) + KW'(peer_stiff_r);
      p1_rsum_r       <= KW'(own_damp_r) + KW'(peer_damp_r);
      p2_pk_r         <= p2_pk_nxt;
      p2_t2_r         <= p2_t2_nxt;
      p2_sneg_r       <= p1_sneg_r;
      p2_sdneg_r      <= p1_sdneg_r;
      p2_mode_r       <= p1_mode_r;
      p3_t1_r         <= p3_t1_nxt;
      p3_t2_r         <= p3_t2_nxt;
      p3_mode_r       <= p2_mode_r;
      out_force_res_r <= out_force_nxt;
      out_mode_r      <= p3_mode_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_force_res = out_force_res_r;
  assign out_mode      = out_mode_r;

  a_force_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_mode_r != MODE_TRANSMIT |-> out_force_res_r == '0)
    else $error("nonzero force outside transmitting mode");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without output backpressure");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p3_v_r && !en |=> p3_v_r && $stable(p3_t1_r))
    else $error("pipeline stage lost content under stall");

endmodule
`default_nettype wire
